[rtl/ptc_pkg.sv]
package ptc_pkg;

	// Offset subtracted from the fine temperature before pressure compensation.
	localparam logic [33:0] TF_OFFSET = 34'd128000;
	// Full scale of the 20-bit pressure conversion.
	localparam logic [20:0] ADC_FULL = 21'd1048576;
	// Scale applied to the numerator ahead of the divide.
	localparam logic [11:0] NUM_SCALE = 12'd3125;

	// Divider shape: one quotient bit per stage.
	localparam int NUM_W = 64;
	localparam int DEN_W = 32;
	localparam int DIV_STAGES = NUM_W;

	// Calibration register indexes.
	typedef enum logic [1:0] {
		CFG_TEMP  = 2'd0,
		CFG_PLOW  = 2'd1,
		CFG_PHIGH = 2'd2,
		CFG_PLAST = 2'd3
	} ptc_cfg_idx_t;

	// Fields that ride alongside the divider.
	typedef struct packed {
		logic [31:0] tf;
		logic [31:0] tc;
		logic        pvalid;
		logic        qneg;
	} ptc_side_t;

endpackage

[rtl/pressure_temperature_compensation.sv]
// Integer temperature and pressure compensation for a barometric sensor. Each input
// item is one raw 20-bit temperature and pressure pair; each result item gives the fine
// temperature, the temperature in hundredths of a degree, the pressure in Q24.8 pascals
// (clamped to 0..2^32-1) and a flag that is low, with the pressure zero, when the
// pressure divisor came out zero. The block takes one item every clock cycle while
// s_tready is high. Each item passes 14 stages of partial products and sums, the
// 64-stage signed divider, which produces one quotient bit per stage, 7 stages behind
// it and the output register. A two-entry output stage lets input keep flowing for
// one more item while a result waits. Calibration words are to be written through the
// cfg port by the user only while no item is in flight; the block does not enforce this.
module pressure_temperature_compensation
	import ptc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// raw_temperature [19:0], raw_pressure [39:20]
	input  logic [39:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fine_temperature [31:0], temperature_centi [63:32], pressure_q24_8 [95:64]
	output logic [95:0] m_tdata,
	// pressure_valid [0]
	output logic [0:0]  m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	// Calibration registers.
	logic [47:0] cal_temp_q;
	logic [63:0] cal_plow_q;
	logic [63:0] cal_phigh_q;
	logic [15:0] cal_plast_q;

	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	logic en;
	logic [21:1] vld_s;

	// Stage registers.
	logic [19:0]        adcp_s [1:10];
	logic signed [17:0] a_s1;
	logic signed [16:0] b_s1;
	logic signed [31:0] m1_s2, bb_s2;
	logic signed [31:0] v1_s3, m3_s3;
	logic signed [31:0] tf_s [4:13];
	logic signed [31:0] tc_s [5:13];
	logic signed [33:0] x_s [5:8];
	logic [63:0]        xx_s6, xx_s7;
	logic signed [48:0] pl6_s7, pl3_s8;
	logic [31:0]        ph6_s7, ph3_s8;
	logic [63:0]        w2p_s8, w2p_s9;
	logic [63:0]        w1p_s9;
	logic signed [49:0] xp5_s9, xp2_s9;
	logic [63:0]        w2_s10, w1q_s10;
	logic [47:0]        l1_s11;
	logic [31:0]        h1_s11;
	logic [63:0]        n0_s11;
	logic [31:0]        w1_s12;
	logic [43:0]        nl_s12;
	logic [31:0]        nh_s12;
	logic [63:0]        num_s13;
	logic [31:0]        den_s13;
	logic               pv_s13;
	logic [63:0]        mn_s14;
	logic [31:0]        md_s14;
	ptc_side_t          side_s14;
	ptc_side_t          side_s [15:21];
	logic [63:0]        p_s [15:19];
	logic [63:0]        ll_s16;
	logic [31:0]        cr_s16;
	logic [63:0]        ss_s17;
	logic signed [48:0] pl8_s17, pl9_s18;
	logic [31:0]        ph8_s17, ph9_s18;
	logic [63:0]        w2_s [18:19];
	logic [63:0]        w1_s19;
	logic [63:0]        pp_s20;
	logic [31:0]        res_s21;

	// Combinational terms between stages.
	logic signed [33:0] m1_full, bb_full;
	logic signed [31:0] bb_sh;
	logic signed [35:0] m3_full;
	logic [31:0]        tc_sum;
	logic signed [67:0] xx_full;
	logic signed [48:0] pl6_full, pl3_full, pl8_full, pl9_full;
	logic [31:0]        ph6_full, ph3_full, ph8_full, ph9_full;
	logic [63:0]        w1_sum3;
	logic signed [49:0] xp5_full, xp2_full;
	logic [20:0]        pdiff;
	logic [47:0]        l1_full;
	logic [31:0]        h1_full;
	logic [63:0]        w1_sum, w1_sh;
	logic [43:0]        nl_full;
	logic [31:0]        nh_full;
	logic               qneg;
	logic               div_vld;
	logic [63:0]        div_quo;
	ptc_side_t          div_side;
	logic [63:0]        sv;
	logic [63:0]        ll_full;
	logic [31:0]        cr_full;
	logic [63:0]        w2_sum, w1_sum9;
	logic [63:0]        pp_sh;

	// Output register and skid entry.
	logic        ov_q, sv_q;
	logic [95:0] od_q, sd_q;
	logic        ou_q, su_q;

	// Coefficient fields.
	assign t1 = cal_temp_q[15:0];
	assign t2 = $signed(cal_temp_q[31:16]);
	assign t3 = $signed(cal_temp_q[47:32]);
	assign p1 = cal_plow_q[15:0];
	assign p2 = $signed(cal_plow_q[31:16]);
	assign p3 = $signed(cal_plow_q[47:32]);
	assign p4 = $signed(cal_plow_q[63:48]);
	assign p5 = $signed(cal_phigh_q[15:0]);
	assign p6 = $signed(cal_phigh_q[31:16]);
	assign p7 = $signed(cal_phigh_q[47:32]);
	assign p8 = $signed(cal_phigh_q[63:48]);
	assign p9 = $signed(cal_plast_q);

	// Calibration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q  <= '0;
			cal_plow_q  <= '0;
			cal_phigh_q <= '0;
			cal_plast_q <= '0;
		end else if (cfg_we) begin
			unique case (ptc_cfg_idx_t'(cfg_index))
				CFG_TEMP:  cal_temp_q  <= cfg_wdata[47:0];
				CFG_PLOW:  cal_plow_q  <= cfg_wdata;
				CFG_PHIGH: cal_phigh_q <= cfg_wdata;
				CFG_PLAST: cal_plast_q <= cfg_wdata[15:0];
				default:   cal_plast_q <= cal_plast_q;
			endcase
		end
	end

	// The whole pipeline moves together unless the skid entry is occupied.
	assign en       = !sv_q;
	assign s_tready = en;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= 14; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			vld_s[15] <= div_vld;
			for (int k = 16; k <= 21; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Temperature partial products.
	assign m1_full = a_s1 * t2;
	assign bb_full = b_s1 * b_s1;
	assign bb_sh   = bb_s2 >>> 12;
	assign m3_full = $signed(bb_sh[19:0]) * t3;
	assign tc_sum  = {tf_s[4][29:0], 2'b00} + tf_s[4] + 32'd128;

	// Pressure divisor and offset terms.
	assign xx_full  = x_s[5] * x_s[5];
	assign pl6_full = $signed({1'b0, xx_s6[31:0]}) * p6;
	assign ph6_full = xx_s6[63:32] * {{16{p6[15]}}, p6};
	assign pl3_full = $signed({1'b0, xx_s7[31:0]}) * p3;
	assign ph3_full = xx_s7[63:32] * {{16{p3[15]}}, p3};
	assign w1_sum3  = {{15{pl3_s8[48]}}, pl3_s8} + {ph3_s8, 32'd0};
	assign xp5_full = x_s[8] * p5;
	assign xp2_full = x_s[8] * p2;
	assign l1_full  = w1q_s10[31:0] * p1;
	assign h1_full  = w1q_s10[63:32] * {16'd0, p1};
	assign pdiff    = ADC_FULL - {1'b0, adcp_s[10]};
	assign w1_sum   = {16'd0, l1_s11} + {h1_s11, 32'd0};
	assign w1_sh    = $signed(w1_sum) >>> 33;
	assign nl_full  = n0_s11[31:0] * NUM_SCALE;
	assign nh_full  = n0_s11[63:32] * {20'd0, NUM_SCALE};
	assign qneg     = num_s13[63] ^ den_s13[31];

	// Stages ahead of the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= $signed({1'b0, s_tdata[19:3]}) - $signed({1'b0, s_tdata[15:0] & 16'h0, 1'b0})
				- $signed({1'b0, t1, 1'b0});
			b_s1 <= $signed({1'b0, s_tdata[19:4]}) - $signed({1'b0, t1});
			adcp_s[1] <= s_tdata[39:20];
			for (int k = 2; k <= 10; k++) begin
				adcp_s[k] <= adcp_s[k-1];
			end

			m1_s2 <= m1_full[31:0];
			bb_s2 <= bb_full[31:0];

			v1_s3 <= m1_s2 >>> 11;
			m3_s3 <= m3_full[31:0];

			tf_s[4] <= v1_s3 + (m3_s3 >>> 14);
			for (int k = 5; k <= 13; k++) begin
				tf_s[k] <= tf_s[k-1];
			end

			tc_s[5] <= $signed(tc_sum) >>> 8;
			for (int k = 6; k <= 13; k++) begin
				tc_s[k] <= tc_s[k-1];
			end
			x_s[5] <= $signed({{2{tf_s[4][31]}}, tf_s[4]} - TF_OFFSET);
			for (int k = 6; k <= 8; k++) begin
				x_s[k] <= x_s[k-1];
			end

			xx_s6 <= xx_full[63:0];

			pl6_s7 <= pl6_full;
			ph6_s7 <= ph6_full;
			xx_s7  <= xx_s6;

			w2p_s8 <= {{15{pl6_s7[48]}}, pl6_s7} + {ph6_s7, 32'd0};
			pl3_s8 <= pl3_full;
			ph3_s8 <= ph3_full;

			w1p_s9 <= $signed(w1_sum3) >>> 8;
			xp5_s9 <= xp5_full;
			xp2_s9 <= xp2_full;
			w2p_s9 <= w2p_s8;

			w2_s10  <= w2p_s9 + ({{14{xp5_s9[49]}}, xp5_s9} << 17)
				+ ({{48{p4[15]}}, p4} << 35);
			w1q_s10 <= w1p_s9 + ({{14{xp2_s9[49]}}, xp2_s9} << 12) + (64'd1 << 47);

			l1_s11 <= l1_full;
			h1_s11 <= h1_full;
			n0_s11 <= {12'd0, pdiff, 31'd0} - w2_s10;

			w1_s12 <= w1_sh[31:0];
			nl_s12 <= nl_full;
			nh_s12 <= nh_full;

			num_s13 <= {20'd0, nl_s12} + {nh_s12, 32'd0};
			den_s13 <= w1_s12;
			pv_s13  <= |w1_s12;

			mn_s14   <= num_s13[63] ? 64'(64'd0 - num_s13) : num_s13;
			md_s14   <= den_s13[31] ? 32'(32'd0 - den_s13) : den_s13;
			side_s14 <= '{tf: tf_s[13], tc: tc_s[13], pvalid: pv_s13, qneg: qneg};
		end
	end

	// Signed divide of the scaled numerator by the pressure divisor.
	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s[14]),
		.in_num   (mn_s14),
		.in_den   (md_s14),
		.in_side  (side_s14),
		.out_vld  (div_vld),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	// Second-order pressure correction terms.
	assign sv       = $signed(p_s[15]) >>> 13;
	assign ll_full  = sv[31:0] * sv[31:0];
	assign cr_full  = sv[63:32] * sv[31:0];
	assign pl8_full = $signed({1'b0, p_s[16][31:0]}) * p8;
	assign ph8_full = p_s[16][63:32] * {{16{p8[15]}}, p8};
	assign pl9_full = $signed({1'b0, ss_s17[31:0]}) * p9;
	assign ph9_full = ss_s17[63:32] * {{16{p9[15]}}, p9};
	assign w2_sum   = {{15{pl8_s17[48]}}, pl8_s17} + {ph8_s17, 32'd0};
	assign w1_sum9  = {{15{pl9_s18[48]}}, pl9_s18} + {ph9_s18, 32'd0};
	assign pp_sh    = $signed(p_s[19] + w1_s19 + w2_s[19]) >>> 8;

	// Stages after the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s[15]    <= div_side.qneg ? 64'(64'd0 - div_quo) : div_quo;
			side_s[15] <= div_side;
			for (int k = 16; k <= 21; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 16; k <= 19; k++) begin
				p_s[k] <= p_s[k-1];
			end

			ll_s16 <= ll_full;
			cr_s16 <= cr_full;

			ss_s17  <= ll_s16 + {cr_s16[30:0], 33'd0};
			pl8_s17 <= pl8_full;
			ph8_s17 <= ph8_full;

			pl9_s18  <= pl9_full;
			ph9_s18  <= ph9_full;
			w2_s[18] <= $signed(w2_sum) >>> 19;

			w1_s19   <= $signed(w1_sum9) >>> 25;
			w2_s[19] <= w2_s[18];

			pp_s20 <= pp_sh + ({{48{p7[15]}}, p7} << 4);

			// Clamp to the unsigned 32-bit range; no pressure without a divisor.
			if (!side_s[20].pvalid || pp_s20[63]) begin
				res_s21 <= '0;
			end else if (|pp_s20[62:32]) begin
				res_s21 <= '1;
			end else begin
				res_s21 <= pp_s20[31:0];
			end
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (m_tready) begin
				sv_q <= 1'b0;
			end
		end else if (!ov_q || m_tready) begin
			ov_q <= vld_s[21];
		end else if (vld_s[21]) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (m_tready) begin
				od_q <= sd_q;
				ou_q <= su_q;
			end
		end else if (!ov_q || m_tready) begin
			od_q <= {res_s21, side_s[21].tc, side_s[21].tf};
			ou_q <= side_s[21].pvalid;
		end else begin
			sd_q <= {res_s21, side_s[21].tc, side_s[21].tf};
			su_q <= side_s[21].pvalid;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = ou_q;

endmodule

[rtl/ptc_div.sv]
module ptc_div
	import ptc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  ptc_side_t        in_side,
	output logic             out_vld,
	output logic [NUM_W-1:0] out_quo,
	output ptc_side_t        out_side
);

	logic             vld_s  [DIV_STAGES];
	logic [DEN_W-1:0] rem_s  [DIV_STAGES];
	logic [NUM_W-1:0] nq_s   [DIV_STAGES];
	logic [DEN_W-1:0] den_s  [DIV_STAGES];
	ptc_side_t        side_s [DIV_STAGES];

	// Restoring divide: each stage brings down one numerator bit and
	// shifts the quotient bit into the vacated low end.
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic             vld_in;
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W-1:0] den_in;
		ptc_side_t        side_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign nq_in   = in_num;
			assign den_in  = in_den;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign nq_in   = nq_s[i-1];
			assign den_in  = den_s[i-1];
			assign side_in = side_s[i-1];
		end

		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				nq_s[i]   <= {nq_in[NUM_W-2:0], ge};
				den_s[i]  <= den_in;
				side_s[i] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign out_quo  = nq_s[DIV_STAGES-1];
	assign out_side = side_s[DIV_STAGES-1];

endmodule

[rtl/ptc_checker.sv]
module ptc_checker
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic [95:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tvalid,
	input logic        m_tready
);

	logic [31:0] tc_chk;

	// Centi-degree value recomputed from the fine temperature on the port.
	assign tc_chk = $signed(m_tdata[31:0] * 32'd5 + 32'd128) >>> 8;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Input is only held off after the output side has stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// Without a divisor the pressure field is zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[95:64] == 32'd0)
		else $error("pressure nonzero while flagged invalid");

	// Both temperature fields come from the same item.
	a_temp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:32] == tc_chk)
		else $error("temperature fields disagree");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

[sim/pressure_temperature_compensation_test.sv]
`timescale 1ns / 100ps

module pressure_temperature_compensation_test;
	import ptc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;

	// One compensated reading as the block should report it.
	typedef struct {
		logic [31:0] fine_temp;
		logic [31:0] temp_centi;
		logic [31:0] pressure;
		logic        press_ok;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [39:0] s_tdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;

	// Calibration words as the block should hold them.
	logic [47:0] cal_temp = '0;
	logic [63:0] cal_plow = '0;
	logic [63:0] cal_phigh = '0;
	logic [15:0] cal_plast = '0;

	reading_t expected_readings[$];
	int errors = 0;
	int cycles = 0;
	int hold_from = -1000000;
	int burst_left = 0;

	pressure_temperature_compensation u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Cycle count and run timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** pressure_temperature_compensation: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] sra32(logic [31:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] sext16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// Integer compensation of one raw pair with the current calibration.
	function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp);
		logic [31:0] t1, t2, t3, a, b, v1, v2, tf;
		logic [63:0] x, w1, w2, p, mn, md, q;
		reading_t r;
		t1 = {16'b0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		a = {15'b0, rt[19:3]} - (t1 << 1);
		v1 = sra32(a * t2, 11);
		b = {16'b0, rt[19:4]} - t1;
		v2 = sra32(sra32(b * b, 12) * t3, 14);
		tf = v1 + v2;
		r.fine_temp = tf;
		r.temp_centi = sra32(tf * 32'd5 + 32'd128, 8);
		r.pressure = '0;
		x = {{32{tf[31]}}, tf} - 64'd128000;
		w2 = x * x * sext16(cal_phigh[31:16]);
		w2 = w2 + ((x * sext16(cal_phigh[15:0])) << 17);
		w2 = w2 + (sext16(cal_plow[63:48]) << 35);
		w1 = sra64(x * x * sext16(cal_plow[47:32]), 8)
			+ ((x * sext16(cal_plow[31:16])) << 12);
		w1 = sra64(((64'd1 << 47) + w1) * {48'b0, cal_plow[15:0]}, 33);
		r.press_ok = (w1 != 0);
		if (r.press_ok) begin
			p = 64'd1048576 - {44'b0, rp};
			p = ((p << 31) - w2) * 64'd3125;
			// Signed divide that truncates toward zero and wraps.
			mn = p[63] ? -p : p;
			md = w1[63] ? -w1 : w1;
			q = mn / md;
			p = (p[63] != w1[63]) ? -q : q;
			w1 = sra64(sext16(cal_plast) * sra64(p, 13) * sra64(p, 13), 25);
			w2 = sra64(sext16(cal_phigh[63:48]) * p, 19);
			p = sra64(p + w1 + w2, 8) + (sext16(cal_phigh[47:32]) << 4);
			if (p[63])
				r.pressure = '0;
			else if (p[63:32] != 0)
				r.pressure = 32'hFFFF_FFFF;
			else
				r.pressure = p[31:0];
		end
		return r;
	endfunction

	// Receiver: stall pattern, long hold-off, and result checking.
	always @(posedge clk) begin
		reading_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result item %h/%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = expected_readings.pop_front();
				if (m_tdata[31:0] !== e.fine_temp) begin
					$display("%0t: fine_temperature exp %h got %h", $time, e.fine_temp,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.temp_centi) begin
					$display("%0t: temperature_centi exp %h got %h", $time, e.temp_centi,
						m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== e.pressure) begin
					$display("%0t: pressure_q24_8 exp %h got %h", $time, e.pressure,
						m_tdata[95:64]);
					errors++;
				end
				if (m_tuser[0] !== e.press_ok) begin
					$display("%0t: pressure_valid exp %b got %b", $time, e.press_ok,
						m_tuser[0]);
					errors++;
				end
			end
		end
		if (cycles - hold_from < HOLD_CYCLES)
			m_tready <= 1'b0;
		else case ((cycles >> 8) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			default: m_tready <= ((cycles % 7) >= 3);
		endcase
	end

	// Send one raw pair, with random bursts and gaps ahead of it.
	task automatic send_pair(logic [19:0] rt, logic [19:0] rp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {rp, rt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_readings.push_back(compensate(rt, rp));
	endtask

	// Stop sending and let every outstanding result come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Drive one register write; the caller drops the write enable afterwards.
	task automatic write_cal(ptc_cfg_idx_t idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_TEMP:  cal_temp = data[47:0];
			CFG_PLOW:  cal_plow = data;
			CFG_PHIGH: cal_phigh = data;
			CFG_PLAST: cal_plast = data[15:0];
		endcase
	endtask

	task automatic load_cal(logic [47:0] t, logic [63:0] lo, logic [63:0] hi,
			logic [15:0] last);
		// Upper bits beyond each register's width are junk and must be dropped.
		write_cal(CFG_TEMP, {16'($urandom_range(0, 65535)), t});
		write_cal(CFG_PLOW, lo);
		write_cal(CFG_PHIGH, hi);
		write_cal(CFG_PLAST, {32'($urandom()), 16'($urandom_range(0, 65535)), last});
		cfg_we <= 1'b0;
	endtask

	task automatic load_typical();
		load_cal(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_3C8C_FFF9_008C,
			16'h1770);
	endtask

	task automatic send_extremes();
		send_pair(20'h00000, 20'h00000);
		send_pair(20'hFFFFF, 20'hFFFFF);
		send_pair(20'h00000, 20'hFFFFF);
		send_pair(20'hFFFFF, 20'h00000);
		send_pair(20'h7EED0, 20'h655AC);
		send_pair(20'h80000, 20'h7FFFF);
	endtask

	// Reset calibration leaves P1 at zero, so the divisor is zero.
	task automatic test_zero_divisor();
		send_extremes();
		drain();
	endtask

	task automatic test_typical();
		load_typical();
		send_extremes();
		send_pair(20'h7A000, 20'h50000);
		send_pair(20'h85000, 20'h70000);
		send_pair(20'h55555, 20'hAAAAA);
		drain();
	endtask

	// Settings that drive the pressure below zero and above full scale.
	task automatic test_clamps();
		load_cal(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_8000_FFF9_008C,
			16'h1770);
		send_extremes();
		drain();
		load_cal(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_0001, 64'h7FFF_7FFF_FFF9_008C,
			16'h7FFF);
		send_extremes();
		drain();
		load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			16'hFFFF);
		send_extremes();
		drain();
		load_cal(48'h7FFF_8000_FFFF, 64'h8000_7FFF_8000_FFFF, 64'h8000_7FFF_8000_7FFF,
			16'h8000);
		send_extremes();
		drain();
	endtask

	// Random calibrations, some near typical and some anywhere, with random pairs.
	task automatic test_random();
		logic [19:0] rt, rp;
		for (int s = 0; s < 6; s++) begin
			if (s % 2 == 0)
				load_cal({$urandom(), 16'($urandom())}, {$urandom(), $urandom()},
					{$urandom(), $urandom()}, 16'($urandom()));
			else
				load_cal({16'hFC18 ^ 16'($urandom_range(0, 255)), 16'h6743,
						16'h6B70 ^ 16'($urandom_range(0, 255))},
					{48'h0B27_0BD0_D643, 16'h8E7D ^ 16'($urandom_range(0, 4095))},
					{16'hC6F8, 16'($urandom()), 16'hFFF9, 16'h008C},
					16'($urandom_range(0, 8000)));
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(0, 1)) begin
					rt = 20'($urandom());
					rp = 20'($urandom());
				end else begin
					rt = 20'h7EED0 + 20'($urandom_range(0, 65535)) - 20'h8000;
					rp = 20'h655AC + 20'($urandom_range(0, 131071)) - 20'h10000;
				end
				send_pair(rt, rp);
			end
			drain();
		end
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		load_typical();
		hold_from = cycles;
		for (int i = 0; i < 150; i++)
			send_pair(20'($urandom()), 20'($urandom()));
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_divisor();
		test_typical();
		test_clamps();
		test_random();
		test_backpressure();
		if (errors == 0 && expected_readings.size() == 0)
			$display("** pressure_temperature_compensation: PASSED **");
		else
			$display("** pressure_temperature_compensation: FAILED **");
		$finish;
	end

endmodule

[pressure_temperature_compensation.f]
rtl/ptc_pkg.sv
rtl/ptc_div.sv
rtl/pressure_temperature_compensation.sv
rtl/ptc_checker.sv
sim/pressure_temperature_compensation_test.sv
